// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, sampled on the rising edge of clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, prop)
`define ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

// ===== hw/rtl/dsde_pkg.sv =====
package dsde_pkg;

  localparam int DIGIT_SLOTS = 6;
  localparam int CNT_W = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
  localparam int SLOT_W = 3;
  localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(DIGIT_SLOTS - 1);

  typedef logic [3:0] digit_t;
  typedef digit_t [DIGIT_SLOTS-1:0] digits_t;

  typedef struct packed {
    logic [31:0] quot;
    digit_t      rem;
  } div10_t;

  // quotient by reciprocal multiply, remainder by shift-add back-multiply
  function automatic div10_t div10(input logic [31:0] x);
    logic [63:0] prod;
    logic [31:0] q;
    logic [31:0] back;
    div10_t      r;
    prod = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
    q = 32'(prod >> 35);
    back = (q << 3) + (q << 1);
    r.quot = q;
    r.rem = 4'(x - back);
    return r;
  endfunction

  // first byte in the high half, second byte in the low half
  function automatic logic [15:0] seg_lookup(input digit_t d);
    logic [15:0] s;
    case (d)
      4'd0: s = 16'hFC28;
      4'd1: s = 16'h6020;
      4'd2: s = 16'hDB00;
      4'd3: s = 16'hF300;
      4'd4: s = 16'h6700;
      4'd5: s = 16'hB700;
      4'd6: s = 16'hBF00;
      4'd7: s = 16'hE400;
      4'd8: s = 16'hFF00;
      4'd9: s = 16'hF700;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/decimal_segment_display_encoder.sv =====
// Decimal seven-segment encoder: each number transfer on the slave side gives
// DIGIT_SLOTS (six) slot transfers on the master side, slot 0 (rightmost) first,
// tlast on the final one. Digits are peeled off by a chain of six divide-by-ten
// stages (one reciprocal multiply each), each one registered, and an item passes
// through all of them before its slot writes start; after that one slot leaves
// per cycle while m_tready is high. A new number is taken while the previous one
// is still being sent, so the rate is set by the single output slot per cycle.
// Leading zeros are blanked, slots up to the decimal point are always shown,
// and numbers above 999999 show their low six digits.
`include "assert_macros.svh"

module decimal_segment_display_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // number[31:0], point_position[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // slot[2:0], blank[3], segments_first[11:4],
                                 // segments_second[19:12], zero[23:20]
  output logic        m_tlast
);

  localparam int N = dsde_pkg::DIGIT_SLOTS;
  localparam int CW = dsde_pkg::CNT_W;

  // digit extraction chain
  logic                     pv       [N];
  logic [31:0]              quot     [N];
  dsde_pkg::digits_t        dig      [N];
  dsde_pkg::digits_t        dig_next [N];
  logic [CW-1:0]            pt       [N];

  // slot serializer
  logic                     busy;
  logic [CW-1:0]            cnt;
  dsde_pkg::digits_t        dig_s;
  logic [N-1:0]             vis;
  logic [N-1:0]             vis_next;
  logic [CW-1:0]            pt_s;

  logic                     ser_take;
  logic                     adv;
  logic [CW-1:0]            pt_in;
  dsde_pkg::div10_t         dv       [N];

  assign ser_take = !busy || (m_tready && cnt == dsde_pkg::LAST_SLOT);
  assign adv = !pv[N-1] || ser_take;
  assign s_tready = adv;

  always_comb begin
    if (s_tdata[47:32] < 16'(N)) begin
      pt_in = CW'(s_tdata[47:32]);
    end else begin
      pt_in = '0;
    end
    dv[0] = dsde_pkg::div10(s_tdata[31:0]);
    dig_next[0] = '0;
    dig_next[0][0] = dv[0].rem;
    for (int s = 1; s < N; s++) begin
      dv[s] = dsde_pkg::div10(quot[s-1]);
      dig_next[s] = dig[s-1];
      dig_next[s][s] = dv[s].rem;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quot[0] <= dv[0].quot;
      dig[0] <= dig_next[0];
      pt[0] <= pt_in;
      for (int s = 1; s < N; s++) begin
        quot[s] <= dv[s].quot;
        dig[s] <= dig_next[s];
        pt[s] <= pt[s-1];
      end
    end
    if (rst) begin
      for (int s = 0; s < N; s++) begin
        pv[s] <= 1'b0;
      end
    end else if (adv) begin
      pv[0] <= s_tvalid;
      for (int s = 1; s < N; s++) begin
        pv[s] <= pv[s-1];
      end
    end
  end

  // a slot is shown at slot 0, up to the point, at or below a nonzero digit, or if the number has more than six digits
  always_comb begin
    logic any;
    for (int p = 0; p < N; p++) begin
      any = (quot[N-1] != 32'd0);
      for (int j = p; j < N; j++) begin
        any = any | (dig[N-1][j] != 4'd0);
      end
      vis_next[p] = (p == 0) || (CW'(p) <= pt[N-1]) || any;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take && pv[N-1]) begin
      dig_s <= dig[N-1];
      vis <= vis_next;
      pt_s <= pt[N-1];
    end
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (ser_take) begin
      busy <= pv[N-1];
      cnt <= '0;
    end else if (m_tready) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_comb begin
    logic [15:0] seg;
    logic [7:0]  second;
    logic        blank;
    seg = dsde_pkg::seg_lookup(dig_s[cnt]);
    second = seg[7:0];
    if (cnt != '0) begin
      second[0] = (cnt == pt_s);
    end
    blank = !vis[cnt];
    m_tvalid = busy;
    m_tlast = (cnt == dsde_pkg::LAST_SLOT);
    m_tdata = '0;
    m_tdata[2:0] = dsde_pkg::SLOT_W'(cnt);
    m_tdata[3] = blank;
    m_tdata[11:4] = blank ? 8'h00 : seg[15:8];
    m_tdata[19:12] = blank ? 8'h00 : second;
  end

  `ASSERT_NEXT(a_more_slots, m_tvalid && m_tready && !m_tlast, m_tvalid)
  `ASSERT_AT(a_slot0_shown, (m_tvalid && cnt == '0) |-> !m_tdata[3])
  `ASSERT_NEXT(a_in_enters, s_tvalid && s_tready, pv[0])
  `ASSERT_NEXT(a_hold_on_stall, m_tvalid && !m_tready, $stable(m_tdata) && m_tvalid)

endmodule
